FILE: design/mtm_pkg.sv
// Shared types and constants for the masked temporal mean composite block.
// Used by mtm_accum, mtm_divider and masked_temporal_mean_composite.
`timescale 1ns / 1ps

package mtm_pkg;

    localparam int NUM_BANDS  = 4;
    localparam int BAND_W     = 16;
    localparam int SUM_W      = 22;
    localparam int CNT_W      = 7;
    localparam int MEAN_W     = 16;
    localparam int NUM_W      = 32;
    localparam int DEN_W      = 17;
    localparam int SEL_W      = 2;
    localparam int STEP_W     = 5;
    localparam int NODATA_W   = 8;

    localparam int COUNT_MAX  = 127;
    localparam int MEAN_SCALE = 816;   // 51/1000 in 12.4 is 816/1000
    localparam int DEN_SCALE  = 1000;

    localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [MEAN_W-1:0] MEAN_MAX  = {MEAN_W{1'b1}};
    localparam logic [SEL_W-1:0]  LAST_BAND = SEL_W'(NUM_BANDS - 1);

    typedef logic [SEL_W-1:0] band_sel_t;

    typedef struct packed {
        logic              pixel_in_region;
        logic              sample_valid;
        logic [BAND_W-1:0] band_a;
        logic [BAND_W-1:0] band_b;
        logic [BAND_W-1:0] band_c;
        logic [BAND_W-1:0] band_d;
        logic              last_of_pixel;
    } item_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean_a;
        logic [MEAN_W-1:0] mean_b;
        logic [MEAN_W-1:0] mean_c;
        logic [MEAN_W-1:0] mean_d;
        logic              no_data;
    } result_t;

    typedef struct packed {
        logic      add_en;
        logic      inc_en;
        logic      clear;
        band_sel_t sel;
    } accum_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_FINISH,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

endpackage

FILE: design/mtm_accum.sv
// Per-pixel band sums and valid count, updated one band per cycle
// through a single saturating adder. Depends on mtm_pkg.
`timescale 1ns / 1ps

module mtm_accum
    import mtm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  accum_ctrl_t       ctrl,
    input  logic [BAND_W-1:0] band_value,
    output logic [SUM_W-1:0]  sum_sel,
    output logic [CNT_W-1:0]  count
);

    logic [SUM_W-1:0] sum_reg [NUM_BANDS];
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W:0]   sum_wide;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign sum_sel = sum_reg[ctrl.sel];
    assign count   = count_reg;

    always_comb
    begin
        sum_wide   = {1'b0, sum_sel} + (SUM_W + 1)'(band_value);
        // saturate at full scale
        sum_next   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        count_next = count_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BANDS; i++)
            begin
                sum_reg[i] <= '0;
            end
            count_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < NUM_BANDS; i++)
            begin
                sum_reg[i] <= '0;
            end
            count_reg <= '0;
        end
        else
        begin
            if (ctrl.add_en)
            begin
                sum_reg[ctrl.sel] <= sum_next;
            end
            if (ctrl.inc_en)
            begin
                count_reg <= count_next;
            end
        end
    end

endmodule

FILE: design/mtm_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on mtm_pkg.
`timescale 1ns / 1ps

module mtm_divider
    import mtm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    logic              run_reg;
    logic              run_next;
    logic              done_reg;
    logic              done_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [NUM_W-1:0]  quo_reg;
    logic [NUM_W-1:0]  quo_next;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [DEN_W-1:0]  div_reg;
    logic [DEN_W-1:0]  div_next;
    logic [DEN_W:0]    partial;
    logic [DEN_W:0]    diff;
    logic              fits;

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        partial   = {rem_reg, quo_reg[NUM_W-1]};
        diff      = partial - {1'b0, div_reg};
        fits      = (partial >= {1'b0, div_reg});
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (run_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            rem_next  = fits ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(NUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

endmodule

FILE: design/masked_temporal_mean_composite.sv
// Top level of the masked temporal mean composite: sequencer, config register,
// output register. Depends on mtm_pkg, mtm_accum and mtm_divider.
`timescale 1ns / 1ps

// Usage:
// Each item beat carries one date sample of the current pixel. A sample with
// sample_valid set is added to the four band sums (saturating) and counted,
// up to MAX_DATES or 127 samples. The beat with last_of_pixel set closes the
// pixel and yields one result beat: four band means scaled by 51/1000, in
// unsigned 12.4, or nodata_value.0 on all bands with no_data set when the
// pixel is outside the region or had no valid sample.
// Sequence: a summed sample has the shared adder walk the four bands in turn.
// A closing sample goes through a setup step, and per band a multiply
// step, a start step and a wait on the one-bit-per-cycle divider, before the
// result goes to the result register. A no-data pixel skips the multiply and
// divider steps.
// The result register holds a finished result while the next pixel's
// samples are taken; once a second result is ready the sequencer stops
// taking samples until the receiver has taken the first. Reset clears sums,
// count and the result valid, and sets nodata_value to 255. nodata_value is
// the only APB register; paddr is not decoded, so it answers at any address.

module masked_temporal_mean_composite
    import mtm_pkg::*;
#(
    parameter int MAX_DATES = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                item_valid,
    output logic                item_ready,
    input  item_t               item_data,
    output logic                res_valid,
    input  logic                res_ready,
    output result_t             res_data
);

    localparam logic [CNT_W-1:0] COUNT_LIMIT =
        CNT_W'((MAX_DATES < COUNT_MAX) ? MAX_DATES : COUNT_MAX);

    state_t               state_reg;
    state_t               state_next;
    band_sel_t            band_reg;
    band_sel_t            band_next;
    item_t                item_reg;
    logic                 nodata_flag_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [MEAN_W-1:0]    mean_reg [NUM_BANDS];
    result_t              res_reg;
    result_t              res_next;
    logic                 res_valid_reg;
    logic [NODATA_W-1:0]  nodata_value_reg;

    accum_ctrl_t          accum_ctrl;
    logic [BAND_W-1:0]    band_value;
    logic [SUM_W-1:0]     sum_sel;
    logic [CNT_W-1:0]     count;
    logic                 div_start;
    logic                 div_done;
    logic [NUM_W-1:0]     quotient;
    logic [MEAN_W-1:0]    mean_sat;
    logic                 item_accept;
    logic                 out_free;
    logic                 load_out;
    logic                 cfg_write;
    logic [MEAN_W-1:0]    nodata_mean;

    assign pready      = 1'b1;
    assign prdata      = {{(32 - NODATA_W){1'b0}}, nodata_value_reg};
    assign cfg_write   = psel && penable && pwrite;
    assign item_accept = item_valid && item_ready;
    assign out_free    = !res_valid_reg || res_ready;
    assign res_valid   = res_valid_reg;
    assign res_data    = res_reg;
    assign nodata_mean = {{(MEAN_W - NODATA_W - 4){1'b0}}, nodata_value_reg, 4'b0000};
    assign mean_sat    = (quotient[NUM_W-1:MEAN_W] != '0) ? MEAN_MAX : quotient[MEAN_W-1:0];

    always_comb
    begin
        case (band_reg)
            2'd0:    band_value = item_reg.band_a;
            2'd1:    band_value = item_reg.band_b;
            2'd2:    band_value = item_reg.band_c;
            default: band_value = item_reg.band_d;
        endcase
    end

    mtm_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (accum_ctrl),
        .band_value (band_value),
        .sum_sel    (sum_sel),
        .count      (count)
    );

    mtm_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (item_data.sample_valid && (count < COUNT_LIMIT))
                    begin
                        state_next = ST_ACC;
                    end
                    else if (item_data.last_of_pixel)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_ACC:
            begin
                if (band_reg == LAST_BAND)
                begin
                    state_next = item_reg.last_of_pixel ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                if (!item_reg.pixel_in_region || (count == '0))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:      state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (band_reg == LAST_BAND) ? ST_OUT : ST_MUL;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        item_ready       = 1'b0;
        accum_ctrl       = '0;
        accum_ctrl.sel   = band_reg;
        div_start        = 1'b0;
        load_out         = 1'b0;
        band_next        = band_reg;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                band_next  = '0;
            end
            ST_ACC:
            begin
                accum_ctrl.add_en = 1'b1;
                accum_ctrl.inc_en = (band_reg == LAST_BAND);
                band_next         = band_reg + SEL_W'(1);
            end
            ST_DIV_GO:
            begin
                div_start = 1'b1;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    band_next = band_reg + SEL_W'(1);
                end
            end
            ST_OUT:
            begin
                load_out         = out_free;
                accum_ctrl.clear = out_free;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (nodata_flag_reg)
        begin
            res_next.mean_a  = nodata_mean;
            res_next.mean_b  = nodata_mean;
            res_next.mean_c  = nodata_mean;
            res_next.mean_d  = nodata_mean;
            res_next.no_data = 1'b1;
        end
        else
        begin
            res_next.mean_a  = mean_reg[0];
            res_next.mean_b  = mean_reg[1];
            res_next.mean_c  = mean_reg[2];
            res_next.mean_d  = mean_reg[3];
            res_next.no_data = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            band_reg         <= '0;
            res_valid_reg    <= 1'b0;
            nodata_value_reg <= 8'd255;
        end
        else
        begin
            state_reg <= state_next;
            band_reg  <= band_next;
            if (load_out)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                nodata_value_reg <= pwdata[NODATA_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            item_reg <= item_data;
        end
        if (state_reg == ST_FINISH)
        begin
            nodata_flag_reg <= !item_reg.pixel_in_region || (count == '0);
            den_reg         <= DEN_W'(count) * DEN_W'(DEN_SCALE);
        end
        // numerator with half the divisor added for round-half-up
        if (state_reg == ST_MUL)
        begin
            num_reg <= NUM_W'(sum_sel) * NUM_W'(MEAN_SCALE) + NUM_W'(den_reg >> 1);
        end
        if ((state_reg == ST_DIV_WAIT) && div_done)
        begin
            mean_reg[band_reg] <= mean_sat;
        end
        if (load_out)
        begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: sim/masked_temporal_mean_composite_tb.sv
// Self-checking testbench for masked_temporal_mean_composite: a directed table, then random
// pixels, checked against an in-bench per-pixel band mean predictor or pinned table values.
// Depends on mtm_pkg (item_t, result_t) and the masked_temporal_mean_composite RTL.
`timescale 1ns / 1ps

module masked_temporal_mean_composite_tb;
    import mtm_pkg::item_t;
    import mtm_pkg::result_t;

    localparam int              MAX_DATES   = 64;
    localparam int              DATE_LIMIT  = (MAX_DATES < 127) ? MAX_DATES : 127;
    localparam logic [21:0]     SUM_CEIL    = 22'h3FFFFF;
    localparam longint unsigned MEAN_CEIL   = 65535;
    localparam logic [1:0]      REG_NODATA  = 2'd0;
    localparam int              HOLD_CYCLES = 600;
    localparam int              DRAIN_GUARD = 10;
    localparam int              TAIL_CYCLES = 300;

    localparam logic [15:0] ND_DEFAULT = 16'd4080;   // 255.0 in 12.4
    localparam logic [15:0] MEAN_TOP   = 16'd53477;  // single sample of 65535
    localparam logic [15:0] MEAN_10K   = 16'd8160;   // single sample of 10000

    typedef struct packed {
        logic        region;
        logic        valid;
        logic        last;
        logic [15:0] a, b, c, d;
        logic        pinned;
        logic [15:0] ma, mb, mc, md;
        logic        nd;
    } step_row_t;

    localparam int NUM_STEPS = 20;

    // region, valid, last, bands a..d | pinned, means a..d, no_data
    step_row_t steps [NUM_STEPS] = '{
        '{1'b0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          1'b1, ND_DEFAULT, ND_DEFAULT, ND_DEFAULT, ND_DEFAULT, 1'b1},
        '{1'b1, 1'b0, 1'b1, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0,
          1'b1, ND_DEFAULT, ND_DEFAULT, ND_DEFAULT, ND_DEFAULT, 1'b1},
        '{1'b1, 1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0},
        '{1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          1'b1, MEAN_TOP, MEAN_TOP, MEAN_TOP, MEAN_TOP, 1'b0},
        '{1'b1, 1'b1, 1'b1, 16'd10000, 16'd1, 16'd0, 16'hFFFF,
          1'b1, MEAN_10K, 16'd1, 16'd0, MEAN_TOP, 1'b0},
        '{1'b0, 1'b1, 1'b0, 16'd100, 16'd200, 16'd300, 16'd400,
          1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0},
        '{1'b1, 1'b1, 1'b1, 16'd101, 16'd202, 16'd303, 16'd404,
          1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0},
        '{1'b1, 1'b1, 1'b0, 16'd5000, 16'd6000, 16'd7000, 16'd8000,
          1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0},
        '{1'b1, 1'b1, 1'b0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
          1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0},
        '{1'b0, 1'b1, 1'b1, 16'd1, 16'd2, 16'd3, 16'd4,
          1'b1, ND_DEFAULT, ND_DEFAULT, ND_DEFAULT, ND_DEFAULT, 1'b1},
        '{1'b1, 1'b1, 1'b0, 16'hAAAA, 16'h5555, 16'h00FF, 16'hFF00,
          1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0},
        '{1'b1, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0},
        '{1'b1, 1'b1, 1'b0, 16'd1, 16'd1, 16'd1, 16'd1,
          1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0},
        '{1'b0, 1'b1, 1'b0, 16'd2, 16'd2, 16'd2, 16'd2,
          1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0},
        '{1'b1, 1'b1, 1'b1, 16'd3, 16'd3, 16'd3, 16'd3,
          1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 16'd7, 16'd7, 16'd7, 16'd7,
          1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0},
        '{1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          1'b1, ND_DEFAULT, ND_DEFAULT, ND_DEFAULT, ND_DEFAULT, 1'b1},
        '{1'b1, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          1'b1, ND_DEFAULT, ND_DEFAULT, ND_DEFAULT, ND_DEFAULT, 1'b1}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid;
    logic        item_ready;
    item_t       item_data;
    logic        res_valid;
    logic        res_ready;
    result_t     res_data;

    // predictor state
    logic [21:0] band_sum [4];
    logic [6:0]  dates_used;
    logic [7:0]  nodata_cfg;

    result_t     pending_means [$];
    int unsigned errors = 0;
    int unsigned counted_beats = 0;
    logic        pin_flag;
    result_t     pin_val;
    bit          rush = 1'b0;
    bit          hold_results = 1'b0;

    masked_temporal_mean_composite #(
        .MAX_DATES (MAX_DATES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    function automatic logic [15:0] scaled_mean(input logic [21:0] total, input logic [6:0] n);
        longint unsigned den;
        longint unsigned q;
        den = 64'(n) * 1000;
        q = (64'(total) * 816 + den / 2) / den;
        return (q > MEAN_CEIL) ? 16'hFFFF : q[15:0];
    endfunction

    // Fold one date sample into the pixel sums; on the closing sample produce the means.
    function automatic bit fold_sample(input item_t it, output result_t means);
        logic [15:0] band [4];
        logic [22:0] total;
        logic [15:0] m [4];
        band[0] = it.band_a;
        band[1] = it.band_b;
        band[2] = it.band_c;
        band[3] = it.band_d;
        means = '0;
        if (it.sample_valid && dates_used < DATE_LIMIT)
        begin
            for (int k = 0; k < 4; k++)
            begin
                total = band_sum[k] + band[k];
                band_sum[k] = (total > SUM_CEIL) ? SUM_CEIL : total[21:0];
            end
            dates_used++;
        end
        if (!it.last_of_pixel)
            return 1'b0;
        if (!it.pixel_in_region || dates_used == 0)
        begin
            for (int k = 0; k < 4; k++)
                m[k] = {nodata_cfg, 4'b0000};
            means.no_data = 1'b1;
        end
        else
        begin
            for (int k = 0; k < 4; k++)
                m[k] = scaled_mean(band_sum[k], dates_used);
            means.no_data = 1'b0;
        end
        means.mean_a = m[0];
        means.mean_b = m[1];
        means.mean_c = m[2];
        means.mean_d = m[3];
        for (int k = 0; k < 4; k++)
            band_sum[k] = '0;
        dates_used = '0;
        return 1'b1;
    endfunction

    task automatic check_result(input result_t got);
        result_t want;
        if (pending_means.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing pending: %h", got));
            return;
        end
        want = pending_means.pop_front();
        if (got.mean_a !== want.mean_a || got.mean_b !== want.mean_b ||
            got.mean_c !== want.mean_c || got.mean_d !== want.mean_d ||
            got.no_data !== want.no_data)
            report_mismatch($sformatf("got %0d %0d %0d %0d nd=%b, want %0d %0d %0d %0d nd=%b",
                got.mean_a, got.mean_b, got.mean_c, got.mean_d, got.no_data,
                want.mean_a, want.mean_b, want.mean_c, want.mean_d, want.no_data));
    endtask

    always @(posedge clk)
    begin
        result_t means;
        if (rst_n)
        begin
            if (res_valid && res_ready)
                check_result(res_data);
            if (item_valid && item_ready && fold_sample(item_data, means))
                pending_means.insert(pending_means.size(), pin_flag ? pin_val : means);
        end
    end

    // Result side: random stall after each beat, plus one long hold-off on request.
    initial
    begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        res_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_valid && res_ready)
                stall_left = rush ? 0 : $urandom_range(0, 4);
            if (hold_results)
            begin
                hold_results = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left != 0)
            begin
                res_ready <= 1'b0;
                stall_left--;
            end
            else
                res_ready <= 1'b1;
        end
    end

    task automatic send_beat(input item_t it, input logic pinned, input result_t pin);
        int unsigned gap;
        gap = rush ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= it;
        pin_flag   <= pinned;
        pin_val    <= pin;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        counted_beats++;
    endtask

    function automatic logic [15:0] draw_band();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input int unsigned len, input int unsigned valid_pct,
                              input logic region);
        item_t it;
        for (int unsigned i = 0; i < len; i++)
        begin
            it.last_of_pixel   = (i == len - 1);
            // region only counts on the closing sample; scramble it elsewhere
            it.pixel_in_region = it.last_of_pixel ? region : 1'($urandom);
            it.sample_valid    = ($urandom_range(0, 99) < valid_pct);
            it.band_a          = draw_band();
            it.band_b          = draw_band();
            it.band_c          = draw_band();
            it.band_d          = draw_band();
            send_beat(it, 1'b0, '0);
        end
    endtask

    task automatic random_pixel();
        int unsigned len;
        int unsigned pct;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            len = $urandom_range(1, 6);
        else if (pick < 19)
            len = $urandom_range(7, 24);
        else
            len = $urandom_range(40, 70);
        case ($urandom_range(0, 5))
            0: pct = 0;
            1: pct = 30;
            2, 3: pct = 70;
            default: pct = 100;
        endcase
        rush = ($urandom_range(0, 3) == 0);
        send_pixel(len, pct, $urandom_range(0, 7) != 0);
    endtask

    task automatic run_pixels(input int unsigned quota);
        int unsigned stop_at;
        stop_at = counted_beats + quota;
        while (counted_beats < stop_at)
            random_pixel();
        rush = 1'b0;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        // let the predictor take the last accepted beat first
        @(posedge clk);
        while (pending_means.size() != 0) @(posedge clk);
        repeat (DRAIN_GUARD) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_NODATA;
        pwdata  <= wr ? {24'h0, value} : 32'h0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (wr)
            nodata_cfg = value;
        else if (prdata !== {24'h0, nodata_cfg})
            report_mismatch($sformatf("nodata_value read %h, want %h", prdata, nodata_cfg));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_nodata(input logic [7:0] value);
        drain();
        apb_access(1'b1, value);
        apb_access(1'b0, 8'h00);
    endtask

    initial
    begin : stimulus
        item_t   it;
        result_t pin;
        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= REG_NODATA;
        pwdata     <= 32'h0;
        item_valid <= 1'b0;
        item_data  <= '0;
        pin_flag   <= 1'b0;
        pin_val    <= '0;
        for (int k = 0; k < 4; k++)
            band_sum[k] = '0;
        dates_used = '0;
        nodata_cfg = 8'd255;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_access(1'b0, 8'h00);

        foreach (steps[r])
        begin
            it.pixel_in_region = steps[r].region;
            it.sample_valid    = steps[r].valid;
            it.last_of_pixel   = steps[r].last;
            it.band_a          = steps[r].a;
            it.band_b          = steps[r].b;
            it.band_c          = steps[r].c;
            it.band_d          = steps[r].d;
            pin.mean_a         = steps[r].ma;
            pin.mean_b         = steps[r].mb;
            pin.mean_c         = steps[r].mc;
            pin.mean_d         = steps[r].md;
            pin.no_data        = steps[r].nd;
            send_beat(it, steps[r].pinned, pin);
        end

        set_nodata(8'd0);
        run_pixels(70);

        // hold results off for a long stretch while samples keep coming
        set_nodata(8'd255);
        hold_results = 1'b1;
        run_pixels(70);

        set_nodata(8'd1);
        run_pixels(40);
        drain();
        run_pixels(40);

        // push the valid count into its limit
        set_nodata(8'h80);
        send_pixel(65, 100, 1'b1);
        send_pixel(72, 95, 1'b1);
        send_pixel(3, 100, 1'b0);
        send_pixel(2, 0, 1'b1);

        set_nodata(8'($urandom_range(2, 254)));
        run_pixels(70);

        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_means.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("masked_temporal_mean_composite_tb OK");
        else
            $display("masked_temporal_mean_composite_tb NOT OK");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("masked_temporal_mean_composite_tb NOT OK");
        $finish;
    end

endmodule
